FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the block clock, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked on the next clock.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/hsm_pkg.sv
// Types, codes and constants of the hart state manager.
package hsm_pkg;

   localparam int DEFAULT_MAX_HARTS = 8;

   localparam int HART_ID_W   = 10;
   localparam int HART_CNT_W  = 4;
   localparam int BOOT_HART_W = 3;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 4;
   localparam int LIMIT_W     = 11;

   localparam logic [HART_CNT_W-1:0]  HART_COUNT_RESET = 4'd8;
   localparam logic [BOOT_HART_W-1:0] BOOT_HART_RESET  = 3'd0;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HART_COUNT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOOT_HART  = 4'd1;

   // Request kinds
   localparam logic [1:0] REQ_START  = 2'd0;
   localparam logic [1:0] REQ_STATUS = 2'd1;
   localparam logic [1:0] REQ_BEGIN  = 2'd2;
   localparam logic [1:0] REQ_INIT   = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_PARAM = 2'd1;
   localparam logic [1:0] ERR_AVAIL = 2'd2;
   localparam logic [1:0] ERR_HALT  = 2'd3;

   // Core lifecycle states
   localparam logic [1:0] ST_STARTED = 2'd0;
   localparam logic [1:0] ST_STOPPED = 2'd1;
   localparam logic [1:0] ST_PENDING = 2'd2;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [HART_ID_W-1:0] hart_id;
      logic [63:0]          start_addr;
      logic [63:0]          opaque_arg;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  error_code;
      logic [1:0]  hart_status;
      logic [63:0] jump_addr;
      logic [63:0] jump_arg;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]  state;
      logic [63:0] addr;
      logic [63:0] arg;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{state: ST_STOPPED, addr: 64'd0, arg: 64'd0};

   typedef struct packed {
      logic         wr_en;
      entry_type    wr_entry;
      rsp_item_type rsp;
   } upd_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_EXEC
   } seq_state_type;

endpackage

FILE: rtl/core/hart_state_manager.sv
// Hart state manager: per-core lifecycle state, entry address and argument.
// Flow: an accepted request's entry is read into a register, then updated and
// written back in EXEC; its response goes to the output register or, if that is
// stalled, the skid entry. No request is taken in EXEC or with the skid full.
// Reset: all cores stopped with zero address and argument via per-entry valid
// bits, cleared at once; hart_count = 8, boot_hart = 0; no clearing pass.
module hart_state_manager
   import hsm_pkg::*;
#(
   parameter int MAX_HARTS = DEFAULT_MAX_HARTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_item_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_item_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "assert_macros.svh"

   localparam int IDX_W = (MAX_HARTS > 1) ? $clog2(MAX_HARTS) : 1;

   seq_state_type          state_ff, state_in;
   req_item_type           req_ff;
   logic [HART_CNT_W-1:0]  hart_count_ff;
   logic [BOOT_HART_W-1:0] boot_hart_ff;
   logic                   req_accept;
   logic                   exec;
   logic                   skid_full;
   entry_type              rd_entry;
   upd_type                upd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hart_count_ff <= HART_COUNT_RESET;
         boot_hart_ff  <= BOOT_HART_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HART_COUNT: hart_count_ff <= csr_wdata[HART_CNT_W-1:0];
            CSR_BOOT_HART:  boot_hart_ff  <= csr_wdata[BOOT_HART_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      exec       = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            req_ready = !skid_full;
            if (req_valid && !skid_full) begin
               state_in = SEQ_EXEC;
            end
         end
         SEQ_EXEC: begin
            exec     = 1'b1;
            state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
   end

   // busy state keeps the next read behind this write-back, no forwarding needed
   hsm_entry_ram #(
      .MAX_HARTS (MAX_HARTS),
      .IDX_W     (IDX_W)
   ) u_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (req_data.hart_id[IDX_W-1:0]),
      .rd_entry (rd_entry),
      .wr_en    (exec && upd.wr_en),
      .wr_addr  (req_ff.hart_id[IDX_W-1:0]),
      .wr_entry (upd.wr_entry)
   );

   hsm_update #(
      .MAX_HARTS (MAX_HARTS)
   ) u_update (
      .req        (req_ff),
      .entry      (rd_entry),
      .hart_count (hart_count_ff),
      .boot_hart  (boot_hart_ff),
      .upd        (upd)
   );

   hsm_rsp_buf u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (exec),
      .load_data (upd.rsp),
      .skid_full (skid_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `ASSERT_NEXT(a_accept_exec, req_accept, state_ff == SEQ_EXEC, "accepted request not executed")
   `ASSERT_NEXT(a_exec_once, state_ff == SEQ_EXEC, state_ff == SEQ_IDLE, "request executed twice")
   `ASSERT_CLK(a_no_load_full, !(exec && skid_full), "response lost: skid full on load")
   `ASSERT_CLK(a_skid_implies_out, !skid_full || rsp_valid, "skid holds data with output empty")

endmodule

FILE: rtl/core/hsm_entry_ram.sv
// Per-core entry memory with registered read and per-entry valid bits.
module hsm_entry_ram
   import hsm_pkg::*;
#(
   parameter int MAX_HARTS = DEFAULT_MAX_HARTS,
   parameter int IDX_W     = (MAX_HARTS > 1) ? $clog2(MAX_HARTS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_entry,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_entry
);

   entry_type              entry_mem_ff [MAX_HARTS];
   logic [MAX_HARTS-1:0]   valid_ff;
   logic [MAX_HARTS-1:0]   valid_in;
   entry_type              rd_data_ff;
   logic                   rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= entry_mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // never-written entries read as stopped with zero address and argument
   assign rd_entry = rd_valid_ff ? rd_data_ff : ENTRY_RESET;

endmodule

FILE: rtl/core/hsm_update.sv
// Lifecycle update: range check, state transition and response for one request.
module hsm_update
   import hsm_pkg::*;
#(
   parameter int MAX_HARTS = DEFAULT_MAX_HARTS
) (
   input  req_item_type           req,
   input  entry_type              entry,
   input  logic [HART_CNT_W-1:0]  hart_count,
   input  logic [BOOT_HART_W-1:0] boot_hart,
   output upd_type                upd
);

   localparam logic [LIMIT_W-1:0] MAX_LIMIT = LIMIT_W'(MAX_HARTS);

   logic [LIMIT_W-1:0] count_ext;
   logic [LIMIT_W-1:0] limit;
   logic               in_range;
   entry_type          next_entry;

   always_comb begin
      count_ext = LIMIT_W'(hart_count);
      limit     = (count_ext > MAX_LIMIT) ? MAX_LIMIT : count_ext;
      in_range  = LIMIT_W'(req.hart_id) < limit;

      next_entry                = entry;
      upd.wr_en                 = 1'b0;
      upd.rsp.error_code        = ERR_OK;
      upd.rsp.hart_status       = ST_STARTED;
      upd.rsp.jump_addr         = 64'd0;
      upd.rsp.jump_arg          = 64'd0;

      if (!in_range) begin
         upd.rsp.error_code = ERR_PARAM;
      end else begin
         case (req.req_type)
            REQ_START: begin
               if (entry.state == ST_STOPPED) begin
                  next_entry.state = ST_PENDING;
                  next_entry.addr  = req.start_addr;
                  next_entry.arg   = req.opaque_arg;
                  upd.wr_en        = 1'b1;
               end else if (entry.state == ST_STARTED) begin
                  upd.rsp.error_code = ERR_AVAIL;
               end else begin
                  upd.rsp.error_code = ERR_PARAM;
               end
            end
            REQ_STATUS: begin
            end
            REQ_BEGIN: begin
               if (entry.state == ST_PENDING) begin
                  next_entry.state  = ST_STARTED;
                  upd.wr_en         = 1'b1;
                  upd.rsp.jump_addr = entry.addr;
                  upd.rsp.jump_arg  = entry.arg;
               end else begin
                  upd.rsp.error_code = ERR_HALT;
               end
            end
            default: begin
               // init: only the boot core is marked pending, stored values kept
               if (req.hart_id == HART_ID_W'(boot_hart)) begin
                  next_entry.state = ST_PENDING;
                  upd.wr_en        = 1'b1;
               end
            end
         endcase
         upd.rsp.hart_status = next_entry.state;
      end
      upd.wr_entry = next_entry;
   end

endmodule

FILE: rtl/core/hsm_rsp_buf.sv
// Response output register with one skid entry.
module hsm_rsp_buf
   import hsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_data,
   output logic         skid_full,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   logic         rsp_valid_ff, rsp_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;
   rsp_item_type skid_data_ff, skid_data_in;
   logic         take;

   always_comb begin
      take          = rsp_valid_ff && rsp_ready;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (load) begin
         if (!rsp_valid_ff || take) begin
            rsp_data_in  = load_data;
            rsp_valid_in = 1'b1;
         end else begin
            skid_data_in  = load_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign skid_full = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: test/hart_lifecycle_checker.sv
// Checker for the hart state manager: tracks config and per-core lifecycle, scores responses.
`timescale 1ns / 1ps

module hart_lifecycle_checker
   import hsm_pkg::*;
#(
   parameter int MAX_HARTS = DEFAULT_MAX_HARTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_item_type           req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_item_type           rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     outstanding,
   output int                     checked_count
);

   logic [1:0]             core_phase      [MAX_HARTS];
   logic [63:0]            core_entry_addr [MAX_HARTS];
   logic [63:0]            core_entry_arg  [MAX_HARTS];
   logic [HART_CNT_W-1:0]  hart_count_q;
   logic [BOOT_HART_W-1:0] boot_hart_q;
   rsp_item_type           pending_rsp_q [$];
   int                     mismatches = 0;
   int                     matched    = 0;

   // Applies one request to the tracked core table and returns the response it must produce.
   function automatic rsp_item_type predict_lifecycle(input req_item_type rq);
      rsp_item_type r;
      int unsigned  limit;
      int unsigned  k;
      r = '0;
      limit = (hart_count_q > MAX_HARTS) ? MAX_HARTS : hart_count_q;
      if (rq.hart_id >= limit) begin
         r.error_code = ERR_PARAM;
      end else begin
         k = rq.hart_id;
         case (rq.req_type)
            REQ_START: begin
               if (core_phase[k] == ST_STOPPED) begin
                  core_phase[k]      = ST_PENDING;
                  core_entry_addr[k] = rq.start_addr;
                  core_entry_arg[k]  = rq.opaque_arg;
               end else if (core_phase[k] == ST_STARTED) begin
                  r.error_code = ERR_AVAIL;
               end else begin
                  r.error_code = ERR_PARAM;
               end
            end
            REQ_STATUS: ;
            REQ_BEGIN: begin
               if (core_phase[k] == ST_PENDING) begin
                  core_phase[k] = ST_STARTED;
                  r.jump_addr   = core_entry_addr[k];
                  r.jump_arg    = core_entry_arg[k];
               end else begin
                  r.error_code = ERR_HALT;
               end
            end
            default: begin
               if (rq.hart_id == HART_ID_W'(boot_hart_q)) core_phase[k] = ST_PENDING;
            end
         endcase
         r.hart_status = core_phase[k];
      end
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         for (int i = 0; i < MAX_HARTS; i++) begin
            core_phase[i]      = ST_STOPPED;
            core_entry_addr[i] = '0;
            core_entry_arg[i]  = '0;
         end
         hart_count_q = HART_COUNT_RESET;
         boot_hart_q  = BOOT_HART_RESET;
         pending_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HART_COUNT) hart_count_q = csr_wdata[HART_CNT_W-1:0];
            else if (csr_index == CSR_BOOT_HART) boot_hart_q = csr_wdata[BOOT_HART_W-1:0];
         end
         if (req_valid && req_ready) pending_rsp_q.push_back(predict_lifecycle(req_data));
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp_q.size() == 0) begin
               $error("response transfer with no request outstanding: %p", rsp_data);
               mismatches++;
            end else begin
               want = pending_rsp_q.pop_front();
               compare_field("error_code", 64'(want.error_code), 64'(rsp_data.error_code));
               compare_field("hart_status", 64'(want.hart_status), 64'(rsp_data.hart_status));
               compare_field("jump_addr", want.jump_addr, rsp_data.jump_addr);
               compare_field("jump_arg", want.jump_arg, rsp_data.jump_arg);
               matched++;
            end
         end
      end
      fail_count    <= mismatches;
      outstanding   <= pending_rsp_q.size();
      checked_count <= matched;
   end

endmodule

FILE: test/tb_top.sv
// Testbench top for the hart state manager: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;
   import hsm_pkg::*;

   localparam int HARTS         = DEFAULT_MAX_HARTS;
   localparam int RESET_CYCLES  = 9;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 190;
   localparam int NUM_SETTINGS  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = CSR_INDEX_W'(CSR_BOOT_HART + 1);
   localparam logic [HART_ID_W-1:0]   HART_ID_MAX      = '1;
   localparam logic [63:0]            ALL_ONES         = '1;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_item_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_item_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic stall_en   = 1'b0;
   int   stall_left = 0;
   bit   gaps_on    = 1'b0;
   int   cycle_count = 0;
   int   sent_by_kind [4] = '{0, 0, 0, 0};
   int   fail_count;
   int   outstanding;
   int   checked_count;

   hart_state_manager #(
      .MAX_HARTS(HARTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   hart_lifecycle_checker #(
      .MAX_HARTS(HARTS)
   ) lifecycle_chk (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .checked_count(checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still owed", cycle_count, outstanding);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response back-pressure: random bursts of rsp_ready held low while stall_en is set.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Returns with valid still high; the caller lowers it when the stream pauses.
   task automatic send_request(input logic [1:0] kind, input logic [HART_ID_W-1:0] id,
                               input logic [63:0] addr, input logic [63:0] arg);
      req_item_type item;
      item.req_type   = kind;
      item.hart_id    = id;
      item.start_addr = addr;
      item.opaque_arg = arg;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sent_by_kind[kind]++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Both registers, plus one write to an unmapped index that must be dropped.
   task automatic configure(input logic [HART_CNT_W-1:0] count,
                            input logic [BOOT_HART_W-1:0] boot);
      logic [CSR_DATA_W-1:0]  boot_word;
      logic [CSR_INDEX_W-1:0] junk_index;
      boot_word = CSR_DATA_W'($urandom);
      boot_word[BOOT_HART_W-1:0] = boot;
      junk_index = CSR_INDEX_W'(CSR_FIRST_UNUSED + $urandom_range(0, 13));
      write_csr(CSR_HART_COUNT, count);
      write_csr(CSR_BOOT_HART, boot_word);
      write_csr(junk_index, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   function automatic logic [HART_ID_W-1:0] pick_core(input int active);
      return (active == 0) ? HART_ID_W'($urandom_range(0, 9))
                           : HART_ID_W'($urandom_range(0, active - 1));
   endfunction

   // Mostly start/begin and init/begin sequences, the rest loose noise.
   task automatic run_phase(input logic [HART_CNT_W-1:0] count,
                            input logic [BOOT_HART_W-1:0] boot, input bit idle_on);
      int                   active;
      int                   left;
      logic [HART_ID_W-1:0] id;
      wait_drained();
      configure(count, boot);
      gaps_on = idle_on;
      stall_en <= idle_on;
      active = (count > HARTS) ? HARTS : count;
      left = PHASE_ITEMS;
      while (left > 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               id = pick_core(active);
               send_request(REQ_START, id, {$urandom, $urandom}, {$urandom, $urandom});
               left--;
               if ($urandom_range(0, 2) == 0) begin
                  send_request(REQ_STATUS, id, {$urandom, $urandom}, {$urandom, $urandom});
                  left--;
               end
               send_request(REQ_BEGIN, id, {$urandom, $urandom}, {$urandom, $urandom});
               left--;
            end
            4, 5: begin
               send_request(REQ_INIT, HART_ID_W'(boot), {$urandom, $urandom},
                            {$urandom, $urandom});
               send_request(REQ_BEGIN, HART_ID_W'(boot), {$urandom, $urandom},
                            {$urandom, $urandom});
               left -= 2;
            end
            default: begin
               id = ($urandom_range(0, 3) == 0) ? HART_ID_W'($urandom_range(0, HART_ID_MAX))
                                                : HART_ID_W'($urandom_range(0, active + 1));
               send_request(2'($urandom_range(0, 3)), id, {$urandom, $urandom},
                            {$urandom, $urandom});
               left--;
            end
         endcase
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: every request kind, state transition and index extreme.
      gaps_on = 1'b1;
      stall_en <= 1'b1;
      send_request(REQ_STATUS, HART_ID_W'(0), '0, '0);
      send_request(REQ_BEGIN, HART_ID_W'(0), '0, '0);             // begin on a stopped core halts
      send_request(REQ_INIT, HART_ID_W'(3), ALL_ONES, ALL_ONES);  // init on a non-boot core
      send_request(REQ_INIT, HART_ID_W'(0), '0, '0);              // boot core: stopped -> pending
      send_request(REQ_START, HART_ID_W'(0), ALL_ONES, ALL_ONES); // start while pending
      send_request(REQ_BEGIN, HART_ID_W'(0), ALL_ONES, ALL_ONES);
      send_request(REQ_START, HART_ID_W'(0), '0, '0);             // start while started
      send_request(REQ_INIT, HART_ID_W'(0), '0, '0);              // boot core: started -> pending
      send_request(REQ_INIT, HART_ID_W'(0), '0, '0);
      send_request(REQ_BEGIN, HART_ID_W'(0), '0, '0);
      send_request(REQ_START, HART_ID_W'(7), ALL_ONES, ALL_ONES);
      send_request(REQ_STATUS, HART_ID_W'(7), '0, '0);
      send_request(REQ_BEGIN, HART_ID_W'(7), '0, '0);
      send_request(REQ_BEGIN, HART_ID_W'(7), '0, '0);
      send_request(REQ_START, HART_ID_W'(6), 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(REQ_BEGIN, HART_ID_W'(6), '0, '0);
      send_request(REQ_STATUS, HART_ID_W'(HARTS), '0, '0);        // first index past the count
      send_request(REQ_START, HART_ID_MAX, ALL_ONES, ALL_ONES);
      send_request(REQ_BEGIN, HART_ID_W'(512), '0, '0);
      send_request(REQ_INIT, HART_ID_W'(HARTS), '0, '0);
      send_request(REQ_STATUS, HART_ID_W'(1), '0, '0);

      run_phase(4'd2, 3'd1, 1'b1);
      run_phase(4'd0, 3'd0, 1'b1);                      // every index rejected
      run_phase(4'd4, 3'd3, 1'b0);
      run_phase(4'd15, 3'd7, 1'b1);                     // count above the core limit
      run_phase(4'd1, 3'd0, 1'b1);
      run_phase(4'd8, 3'd5, 1'b0);
      run_phase(4'd9, 3'd2, 1'b1);
      run_phase(4'd6, 3'd4, 1'b0);
      wait_drained();

      $display("Covered %0d requests (start %0d, status %0d, begin %0d, init %0d)",
               sent_by_kind[REQ_START] + sent_by_kind[REQ_STATUS] + sent_by_kind[REQ_BEGIN]
               + sent_by_kind[REQ_INIT], sent_by_kind[REQ_START], sent_by_kind[REQ_STATUS],
               sent_by_kind[REQ_BEGIN], sent_by_kind[REQ_INIT]);
      $display("over %0d register settings; %0d responses checked, %0d mismatches",
               NUM_SETTINGS, checked_count, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
